[rtl/core/ssa_pkg.sv]
// Shared types and codes for the sorted shift array.
// No dependencies; used by ssa_cell, sorted_shift_array and the testbench.
package ssa_pkg;

    // Request codes on req_type.
    typedef enum logic [2:0] {
        REQ_INSERT = 3'd0,
        REQ_SORTED = 3'd1,
        REQ_DELETE = 3'd2,
        REQ_CLEAR  = 3'd3,
        REQ_READ   = 3'd4,
        REQ_UBOUND = 3'd5
    } req_code_t;

    // Register indexes on the configuration port.
    localparam logic CFG_LENGTH = 1'b0;
    localparam logic CFG_SIGNED = 1'b1;

    // Operation broadcast to every cell for one cycle.
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     signed_cmp;
    } ssa_ctrl_t;

endpackage

[rtl/core/ssa_cell.sv]
// One entry of the sorted shift array with its neighbor order flag.
// Depends on ssa_pkg.
module ssa_cell #(
    parameter int DEPTH         = 16,
    parameter int ELEMENT_WIDTH = 32,
    parameter int IDX           = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ssa_pkg::ssa_ctrl_t         ctrl,
    input  logic [$clog2(DEPTH)-1:0]   pos,
    input  logic [$clog2(DEPTH+1)-1:0] len,
    input  logic [ELEMENT_WIDTH-1:0]   in_value,
    input  logic [ELEMENT_WIDTH-1:0]   prev_value,
    input  logic [ELEMENT_WIDTH-1:0]   next_value,
    output logic [ELEMENT_WIDTH-1:0]   entry,
    output logic                       ordered
);
    localparam int IW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] IDX_I  = IW'(IDX);
    localparam logic [LW-1:0] IDX_L  = LW'(IDX);
    localparam logic [LW-1:0] IDX_P1 = LW'(IDX + 1);
    localparam logic [ELEMENT_WIDTH-1:0] SIGN = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};

    logic [ELEMENT_WIDTH-1:0] value_reg, value_next;
    logic                     flag_reg, flag_next;
    logic [ELEMENT_WIDTH-1:0] key_own, key_prev, flip;
    logic                     in_use;

    assign in_use = (IDX_L < len);

    always_comb
    begin
        value_next = value_reg;
        if (in_use)
        begin
            case (ctrl.op)
                ssa_pkg::OP_INSERT:
                begin
                    if (IDX_I > pos)
                        value_next = prev_value;
                    else if (IDX_I == pos)
                        value_next = in_value;
                end
                ssa_pkg::OP_DELETE:
                begin
                    if (IDX_P1 == len)
                        value_next = '0;
                    else if (IDX_I >= pos)
                        value_next = next_value;
                end
                ssa_pkg::OP_CLEAR:
                    value_next = '0;
                default:
                    value_next = value_reg;
            endcase
        end
    end

    // Order flag: this entry is not below its lower neighbor.
    assign flip      = ctrl.signed_cmp ? SIGN : '0;
    assign key_own   = value_reg ^ flip;
    assign key_prev  = prev_value ^ flip;
    assign flag_next = (IDX == 0) || !in_use || !(key_own < key_prev);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            flag_reg  <= 1'b1;
        end
        else
        begin
            value_reg <= value_next;
            flag_reg  <= flag_next;
        end
    end

    assign entry   = value_reg;
    assign ordered = flag_reg;

endmodule

[rtl/core/sorted_shift_array.sv]
// Top level of the sorted shift array: request sequencer, search unit, row of cells.
// Depends on ssa_pkg and ssa_cell.
//
//  channel   signals                                        direction
//  request   start, busy, req_type, position, value          in (busy out)
//  result    done, status, read_value, found_index,
//            array_sorted                                   out
//  config    cfg_we, cfg_index, cfg_data                    in
//
// A request is taken when start is high and busy is low. Its result shows for
// one cycle with done high. Insert, delete, clear and read pass through the
// apply, flag and finish states; refused ones go straight to flag and finish;
// sorted insert and upper bound run the binary search first (at most
// clog2(DEPTH+1) steps), one step per cycle through the shared entry select
// and compare.
// Reset clears every entry, length to 16 and unsigned order. The result side
// cannot stall; a new request may start in the cycle a result is shown.
module sorted_shift_array #(
    parameter int DEPTH         = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [3:0]  position,
    input  logic [31:0] value,
    output logic        done,
    output logic        status,
    output logic [31:0] read_value,
    output logic [4:0]  found_index,
    output logic        array_sorted,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);
    localparam int IW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [ELEMENT_WIDTH-1:0] SIGN = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_APPLY,
        S_FLAG,
        S_FIN
    } state_t;

    // Configuration registers.
    logic [4:0] length_reg;
    logic       signed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= 5'd16;
            signed_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ssa_pkg::CFG_LENGTH)
                length_reg <= cfg_data;
            else
                signed_reg <= cfg_data[0];
        end
    end

    state_t                   state_reg;
    logic [2:0]               req_reg;
    logic [IW-1:0]            pos_reg;
    logic [ELEMENT_WIDTH-1:0] val_reg;
    logic [LW-1:0]            len_reg;
    logic                     err_reg;
    logic [LW-1:0]            lo_reg, hi_reg;
    logic [ELEMENT_WIDTH-1:0] rd_reg;
    logic                     done_reg, status_reg, sorted_reg;
    logic [31:0]              read_reg;
    logic [4:0]               found_reg;

    // Entries in use, clamped to the array depth.
    logic [LW-1:0] len_cur;
    logic          err_cur;
    assign len_cur = (32'(length_reg) > DEPTH) ? LW'(DEPTH) : LW'(length_reg);

    always_comb
    begin
        err_cur = (len_cur == '0);
        unique case (req_type) inside
            ssa_pkg::REQ_INSERT, ssa_pkg::REQ_DELETE, ssa_pkg::REQ_READ:
                if (32'(position) >= 32'(len_cur))
                    err_cur = 1'b1;
            ssa_pkg::REQ_SORTED, ssa_pkg::REQ_CLEAR, ssa_pkg::REQ_UBOUND:
                ;
            default:
                err_cur = 1'b1;
        endcase
    end

    // Binary search step: midpoint, shared entry select, compare.
    logic [ELEMENT_WIDTH-1:0] ent [DEPTH];
    logic [DEPTH-1:0]         flags;
    logic [LW:0]              lo_hi_sum;
    logic [IW-1:0]            mid, sel_addr;
    logic [ELEMENT_WIDTH-1:0] sel, flip;
    logic                     go_right;

    assign lo_hi_sum = (LW+1)'(lo_reg) + (LW+1)'(hi_reg);
    assign mid       = IW'(lo_hi_sum >> 1);
    assign sel_addr  = (state_reg == S_SEARCH) ? mid : pos_reg;
    assign sel       = ent[sel_addr];
    assign flip      = signed_reg ? SIGN : '0;
    assign go_right  = !((val_reg ^ flip) < (sel ^ flip));

    // Cell control: one cycle of the shift operation in S_APPLY.
    ssa_pkg::ssa_ctrl_t ctrl;
    logic [IW-1:0]      op_pos;

    always_comb
    begin
        ctrl.signed_cmp = signed_reg;
        ctrl.op         = ssa_pkg::OP_HOLD;
        if (state_reg == S_APPLY)
        begin
            unique case (req_reg) inside
                ssa_pkg::REQ_INSERT, ssa_pkg::REQ_SORTED:
                    ctrl.op = ssa_pkg::OP_INSERT;
                ssa_pkg::REQ_DELETE:
                    ctrl.op = ssa_pkg::OP_DELETE;
                ssa_pkg::REQ_CLEAR:
                    ctrl.op = ssa_pkg::OP_CLEAR;
                default:
                    ctrl.op = ssa_pkg::OP_HOLD;
            endcase
        end
    end

    // Sorted insert uses the slot found by the search.
    assign op_pos = (req_reg == ssa_pkg::REQ_SORTED) ? IW'(lo_reg) : pos_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [ELEMENT_WIDTH-1:0] prev_v, next_v;
            if (gi == 0)
            begin : g_first
                assign prev_v = '0;
            end
            else
            begin : g_mid_lo
                assign prev_v = ent[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign next_v = '0;
            end
            else
            begin : g_mid_hi
                assign next_v = ent[gi+1];
            end

            ssa_cell #(
                .DEPTH         (DEPTH),
                .ELEMENT_WIDTH (ELEMENT_WIDTH),
                .IDX           (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .pos        (op_pos),
                .len        (len_reg),
                .in_value   (val_reg),
                .prev_value (prev_v),
                .next_value (next_v),
                .entry      (ent[gi]),
                .ordered    (flags[gi])
            );
        end
    endgenerate

    // Sequencer and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            req_reg    <= '0;
            pos_reg    <= '0;
            val_reg    <= '0;
            len_reg    <= '0;
            err_reg    <= 1'b0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            rd_reg     <= '0;
            status_reg <= 1'b0;
            read_reg   <= '0;
            found_reg  <= '0;
            sorted_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg <= req_type;
                        pos_reg <= IW'(position);
                        val_reg <= ELEMENT_WIDTH'(value);
                        len_reg <= len_cur;
                        err_reg <= err_cur;
                        rd_reg  <= '0;
                        lo_reg  <= '0;
                        hi_reg  <= (req_type == ssa_pkg::REQ_SORTED) ? len_cur - LW'(1)
                                                                     : len_cur;
                        if (err_cur)
                            state_reg <= S_FLAG;
                        else if (req_type == ssa_pkg::REQ_SORTED
                                 || req_type == ssa_pkg::REQ_UBOUND)
                            state_reg <= S_SEARCH;
                        else
                            state_reg <= S_APPLY;
                    end
                end
                S_SEARCH:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        if (go_right)
                            lo_reg <= LW'(mid) + LW'(1);
                        else
                            hi_reg <= LW'(mid);
                    end
                    else
                        state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    if (req_reg == ssa_pkg::REQ_READ)
                        rd_reg <= sel;
                    state_reg <= S_FLAG;
                end
                S_FLAG:
                    state_reg <= S_FIN;   // cell order flags settle on the new entries
                S_FIN:
                begin
                    done_reg   <= 1'b1;
                    status_reg <= err_reg;
                    read_reg   <= 32'(rd_reg);
                    found_reg  <= (!err_reg && (req_reg == ssa_pkg::REQ_SORTED
                                               || req_reg == ssa_pkg::REQ_UBOUND))
                                  ? 5'(lo_reg) : 5'd0;
                    sorted_reg <= (len_reg != '0) && (&flags);
                    state_reg  <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign read_value   = read_reg;
    assign found_index  = found_reg;
    assign array_sorted = sorted_reg;

    // Checks.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (read_value == '0 && found_index == '0))
        else $error("refused item carries data");

    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (lo_reg <= hi_reg))
        else $error("search bounds crossed");

endmodule

[verif/tb_sorted_shift_array.sv]
// Self-checking testbench for sorted_shift_array: directed and random requests, live config.
// Depends on ssa_pkg (request codes, register indexes) and the sorted_shift_array RTL.
module tb_sorted_shift_array;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = 16;
    localparam int MAX_CYCLE = 200_000;
    localparam int PHASES    = 12;
    localparam int PHASE_LEN = 50;

    // Codes 6 and 7 are not requests; the block must refuse them.
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  req;
        logic [3:0]  position;
        logic [31:0] value;
    } request_t;

    typedef struct packed {
        logic        status;
        logic [31:0] read_value;
        logic [4:0]  found_index;
        logic        sorted;
    } outcome_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    logic        busy;
    logic [2:0]  req_type     = '0;
    logic [3:0]  position     = '0;
    logic [31:0] value        = '0;
    logic        done;
    logic        status;
    logic [31:0] read_value;
    logic [4:0]  found_index;
    logic        array_sorted;
    logic        cfg_we       = 1'b0;
    logic        cfg_index    = ssa_pkg::CFG_LENGTH;
    logic [4:0]  cfg_data     = '0;

    sorted_shift_array dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .position     (position),
        .value        (value),
        .done         (done),
        .status       (status),
        .read_value   (read_value),
        .found_index  (found_index),
        .array_sorted (array_sorted),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Shadow copy of the array and its two registers, kept in step with the block.
    logic [31:0] shadow_entries [DEPTH];
    logic [4:0]  shadow_len    = 5'd16;
    logic        shadow_signed = 1'b0;

    request_t    pending_reqs [$];   // requests waiting to be offered
    outcome_t    outcomes_due [$];   // predicted results, oldest first
    int unsigned err_count   = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_left    = 0;
    int unsigned burst_left  = 0;

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            shadow_entries[i] = '0;
        end
    end

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Order used by both the search and the sortedness flag.
    function automatic bit ranks_below(input logic [31:0] a, input logic [31:0] b);
        if (shadow_signed)
        begin
            return $signed(a) < $signed(b);
        end
        return a < b;
    endfunction

    // Plain binary search: go right while the probe is not above the value.
    // Runs the same way whether or not the entries are in order.
    function automatic int unsigned upper_bound(input int unsigned n, input logic [31:0] v);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (!ranks_below(v, shadow_entries[mid]))
            begin
                lo = mid + 1;
            end
            else
            begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // Shift entries at and above slot up by one; the last entry in use falls off.
    function automatic void shift_in(input int unsigned len, input int unsigned slot,
                                     input logic [31:0] v);
        for (int i = int'(len) - 1; i > int'(slot); i--)
        begin
            shadow_entries[i] = shadow_entries[i - 1];
        end
        shadow_entries[slot] = v;
    endfunction

    function automatic outcome_t predict_outcome(input request_t r);
        outcome_t    o;
        int unsigned len;
        int unsigned slot;
        o   = '0;
        // Lengths above the depth act as the full depth.
        len = (shadow_len > DEPTH) ? DEPTH : 32'(shadow_len);
        if (len == 0)
        begin
            // Empty array: everything refused.
            o.status = 1'b1;
        end
        else
        begin
            case (r.req)
                ssa_pkg::REQ_INSERT:
                begin
                    if (32'(r.position) >= len)
                    begin
                        o.status = 1'b1;
                    end
                    else
                    begin
                        shift_in(len, 32'(r.position), r.value);
                    end
                end
                ssa_pkg::REQ_SORTED:
                begin
                    // Search covers all but the last entry, which is dropped anyway.
                    slot = (len == 1) ? 0 : upper_bound(len - 1, r.value);
                    shift_in(len, slot, r.value);
                    o.found_index = 5'(slot);
                end
                ssa_pkg::REQ_DELETE:
                begin
                    if (32'(r.position) >= len)
                    begin
                        o.status = 1'b1;
                    end
                    else
                    begin
                        for (int unsigned i = 32'(r.position); i + 1 < len; i++)
                        begin
                            shadow_entries[i] = shadow_entries[i + 1];
                        end
                        shadow_entries[len - 1] = '0;
                    end
                end
                ssa_pkg::REQ_CLEAR:
                begin
                    for (int unsigned i = 0; i < len; i++)
                    begin
                        shadow_entries[i] = '0;
                    end
                end
                ssa_pkg::REQ_READ:
                begin
                    if (32'(r.position) >= len)
                    begin
                        o.status = 1'b1;
                    end
                    else
                    begin
                        o.read_value = shadow_entries[r.position];
                    end
                end
                ssa_pkg::REQ_UBOUND:
                begin
                    o.found_index = 5'(upper_bound(len, r.value));
                end
                default:
                begin
                    o.status = 1'b1;
                end
            endcase
        end
        // Sorted flag looks at entries in use after the step; never set when empty.
        o.sorted = (len != 0);
        for (int unsigned i = 0; i + 1 < len; i++)
        begin
            if (ranks_below(shadow_entries[i + 1], shadow_entries[i]))
            begin
                o.sorted = 1'b0;
            end
        end
        return o;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    task automatic queue_req(input logic [2:0] req, input logic [3:0] pos,
                             input logic [31:0] v);
        request_t r;
        r.req      = req;
        r.position = pos;
        r.value    = v;
        pending_reqs.push_back(r);
    endtask

    // Mostly requests that build and search a sorted array, with values that
    // collide often; the rest edits, reads, clears and junk codes.
    function automatic request_t random_request();
        request_t    r;
        int unsigned roll;
        int unsigned eff;
        logic [2:0]  tiny;
        eff  = (shadow_len > DEPTH) ? DEPTH : 32'(shadow_len);
        tiny = 3'($urandom_range(0, 7));
        roll = $urandom_range(0, 99);
        if (roll < 35)
        begin
            r.req = ssa_pkg::REQ_SORTED;
        end
        else if (roll < 55)
        begin
            r.req = ssa_pkg::REQ_UBOUND;
        end
        else if (roll < 70)
        begin
            r.req = ssa_pkg::REQ_READ;
        end
        else if (roll < 80)
        begin
            r.req = ssa_pkg::REQ_INSERT;
        end
        else if (roll < 90)
        begin
            r.req = ssa_pkg::REQ_DELETE;
        end
        else if (roll < 94)
        begin
            r.req = ssa_pkg::REQ_CLEAR;
        end
        else if (roll < 97)
        begin
            r.req = REQ_SPARE_LO;
        end
        else
        begin
            r.req = REQ_SPARE_HI;
        end
        // Mostly in-range positions so edits land; some past the length.
        r.position = 4'($urandom_range(0, 15));
        if (eff != 0 && $urandom_range(0, 3) != 0)
        begin
            r.position = 4'($urandom_range(0, eff - 1));
        end
        case ($urandom_range(0, 9))
            0:       r.value = '0;
            1:       r.value = '1;
            2:       r.value = 32'h8000_0000;
            3:       r.value = 32'h7FFF_FFFF;
            4, 5, 6: r.value = {{29{tiny[2]}}, tiny};   // -4..3, lots of ties
            default: r.value = $urandom();
        endcase
        return r;
    endfunction

    // Register write; shadow follows once the block has taken it.
    task automatic write_reg(input logic idx, input logic [4:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ssa_pkg::CFG_LENGTH)
        begin
            shadow_len = data;
        end
        else
        begin
            shadow_signed = data[0];
        end
    endtask

    // Quiet point for config changes: nothing queued, offered or owed.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || start || outcomes_due.size() != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH %s: got %0h want %0h at cycle %0d",
                 what, got, want, cycle_count);
        err_count++;
    endtask

    // ---------------------------------------------------------------------
    // Driver: offers the next item, holds it while busy, predicts on accept.
    // Random gaps between items, with idle-free bursts now and then.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : driver
        request_t seen;
        request_t nxt;
        if (!rst_n)
        begin
            start    <= 1'b0;
            gap_left <= 0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                // Item taken at this edge.
                seen.req      = req_type;
                seen.position = position;
                seen.value    = value;
                outcomes_due.push_back(predict_outcome(seen));
            end
            if (gap_left != 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_reqs.size() != 0)
            begin
                nxt = pending_reqs.pop_front();
                start    <= 1'b1;
                req_type <= nxt.req;
                position <= nxt.position;
                value    <= nxt.value;
                if (burst_left != 0)
                begin
                    burst_left <= burst_left - 1;
                    gap_left   <= 0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    burst_left <= $urandom_range(8, 32);
                    gap_left   <= 0;
                end
                else
                begin
                    gap_left <= $urandom_range(0, 3);
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: every strobed result against the oldest prediction.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        outcome_t want;
        if (rst_n && done)
        begin
            if (outcomes_due.size() == 0)
            begin
                flag_mismatch("result with no request outstanding", read_value, '0);
            end
            else
            begin
                want = outcomes_due.pop_front();
                if (status !== want.status)
                begin
                    flag_mismatch("status", 32'(status), 32'(want.status));
                end
                if (read_value !== want.read_value)
                begin
                    flag_mismatch("read_value", read_value, want.read_value);
                end
                if (found_index !== want.found_index)
                begin
                    flag_mismatch("found_index", 32'(found_index), 32'(want.found_index));
                end
                if (array_sorted !== want.sorted)
                begin
                    flag_mismatch("array_sorted", 32'(array_sorted), 32'(want.sorted));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Sequence: reset, directed corners, then random phases under new config.
    // ---------------------------------------------------------------------
    initial
    begin
        int unsigned roll;
        logic [4:0]  len_pick;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full depth, unsigned order: edges of position and value, every request.
        write_reg(ssa_pkg::CFG_LENGTH, 5'd16);
        write_reg(ssa_pkg::CFG_SIGNED, 5'd0);
        queue_req(ssa_pkg::REQ_READ,   4'd15, '0);
        queue_req(ssa_pkg::REQ_INSERT, 4'd0,  32'hFFFF_FFFF);
        queue_req(ssa_pkg::REQ_INSERT, 4'd15, 32'h8000_0000);
        queue_req(ssa_pkg::REQ_INSERT, 4'd7,  32'h0000_0001);
        queue_req(ssa_pkg::REQ_SORTED, 4'd0,  32'h7FFF_FFFF);   // search over an unsorted array
        queue_req(ssa_pkg::REQ_UBOUND, 4'd0,  '0);
        queue_req(ssa_pkg::REQ_DELETE, 4'd0,  '0);
        queue_req(ssa_pkg::REQ_DELETE, 4'd15, '0);
        queue_req(REQ_SPARE_LO,        4'd3,  32'h1234_5678);
        queue_req(REQ_SPARE_HI,        4'd9,  32'h8765_4321);
        queue_req(ssa_pkg::REQ_CLEAR,  4'd0,  '0);
        queue_req(ssa_pkg::REQ_SORTED, 4'd0,  32'd5);
        queue_req(ssa_pkg::REQ_SORTED, 4'd0,  32'd5);           // tie goes after the equal one
        queue_req(ssa_pkg::REQ_UBOUND, 4'd0,  32'hFFFF_FFFF);
        wait_idle();

        // Signed order on a short array; positions past the length are refused.
        write_reg(ssa_pkg::CFG_SIGNED, 5'd1);
        write_reg(ssa_pkg::CFG_LENGTH, 5'd4);
        queue_req(ssa_pkg::REQ_SORTED, 4'd0,  32'h8000_0000);
        queue_req(ssa_pkg::REQ_SORTED, 4'd0,  32'h7FFF_FFFF);
        queue_req(ssa_pkg::REQ_INSERT, 4'd4,  32'hDEAD_BEEF);
        queue_req(ssa_pkg::REQ_DELETE, 4'd4,  '0);
        queue_req(ssa_pkg::REQ_READ,   4'd3,  '0);
        wait_idle();

        // Single entry: sorted insert always lands in slot 0.
        write_reg(ssa_pkg::CFG_LENGTH, 5'd1);
        queue_req(ssa_pkg::REQ_SORTED, 4'd0, 32'd9);
        queue_req(ssa_pkg::REQ_UBOUND, 4'd0, 32'd9);
        wait_idle();

        // Zero length refuses everything; a length above depth acts as full.
        write_reg(ssa_pkg::CFG_LENGTH, 5'd0);
        queue_req(ssa_pkg::REQ_READ,  4'd0, '0);
        queue_req(ssa_pkg::REQ_CLEAR, 4'd0, '0);
        wait_idle();
        write_reg(ssa_pkg::CFG_LENGTH, 5'd31);
        queue_req(ssa_pkg::REQ_READ,  4'd15, '0);
        wait_idle();

        // Random phases, each with a fresh length and order.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            roll = $urandom_range(0, 9);
            case (roll)
                0:       len_pick = 5'd1;
                1:       len_pick = 5'd16;
                2:       len_pick = 5'd0;
                3:       len_pick = 5'($urandom_range(17, 31));
                default: len_pick = 5'($urandom_range(2, 15));
            endcase
            write_reg(ssa_pkg::CFG_LENGTH, len_pick);
            write_reg(ssa_pkg::CFG_SIGNED, 5'($urandom_range(0, 1)));
            repeat (PHASE_LEN) pending_reqs.push_back(random_request());
            wait_idle();
        end

        // Allow for a stray late result.
        repeat (12) @(posedge clk);
        if (err_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/ssa_pkg.sv
rtl/core/ssa_cell.sv
rtl/core/sorted_shift_array.sv
verif/tb_sorted_shift_array.sv
